// File: hdl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg - shared types and constants for the IR remote pulse decoder
// Register indexes, reset values, check limits and the packed decoder state.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned FRAME_LEN_DEF = 33;

    // Fixed limits on the two check bytes
    localparam logic [TICK_W-1:0] FIRST_LIMIT  = 16'd135;
    localparam logic [TICK_W-1:0] SECOND_LIMIT = 16'd245;

    // Bit positions of the three frame sections
    localparam logic [POS_W-1:0] FIRST_LO  = 6'd1;
    localparam logic [POS_W-1:0] FIRST_HI  = 6'd8;
    localparam logic [POS_W-1:0] SECOND_LO = 6'd9;
    localparam logic [POS_W-1:0] SECOND_HI = 6'd16;
    localparam logic [POS_W-1:0] DATA_LO   = 6'd17;
    localparam logic [POS_W-1:0] DATA_HI   = 6'd24;

    // Window reset values
    localparam logic [TICK_W-1:0] HEADER_LOW_RST  = 16'd1340;
    localparam logic [TICK_W-1:0] HEADER_HIGH_RST = 16'd1360;
    localparam logic [TICK_W-1:0] REPEAT_LOW_RST  = 16'd9650;
    localparam logic [TICK_W-1:0] REPEAT_HIGH_RST = 16'd9750;
    localparam logic [TICK_W-1:0] ONE_LOW_RST     = 16'd200;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST    = 16'd245;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST    = 16'd105;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = 16'd125;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_LOW  = 3'd0,
        CFG_HEADER_HIGH = 3'd1,
        CFG_REPEAT_LOW  = 3'd2,
        CFG_REPEAT_HIGH = 3'd3,
        CFG_ONE_LOW     = 3'd4,
        CFG_ONE_HIGH    = 3'd5,
        CFG_ZERO_LOW    = 3'd6,
        CFG_ZERO_HIGH   = 3'd7
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FIRST_FAIL  = 2'd1,
        ST_SECOND_FAIL = 2'd2
    } t_status;

    // Decoder state word kept in the state memory
    typedef struct packed {
        logic              recording;
        logic [POS_W-1:0]  position;
        logic              first_fail;
        logic              second_fail;
        logic [BYTE_W-1:0] data_bits;
    } t_dec_state;

    localparam t_dec_state STATE_RST = '{
        recording:   1'b0,
        position:    '0,
        first_fail:  1'b0,
        second_fail: 1'b0,
        data_bits:   '0
    };

    function automatic logic in_window(
        input logic [TICK_W-1:0] v,
        input logic [TICK_W-1:0] lo,
        input logic [TICK_W-1:0] hi
    );
        return (lo <= v) && (v <= hi);
    endfunction

endpackage

// File: hdl/irpd_ram.sv
// ----------------------------------------------------------------------------
// irpd_ram - generic single-port-write, registered-read RAM
// One write port and one read port; read returns the old word on a collision.
// ----------------------------------------------------------------------------
module irpd_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 1,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ir_remote_pulse_decoder.sv
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder - NEC-style IR frame decoder on falling-edge intervals
// Counts a header plus the following intervals, checks the two leading bytes,
// decodes the data byte and flags long-press repeat marks.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall      | i_interval_ticks
//  out      | o_out_valid / i_out_stall    | o_frame_done o_status o_data_byte
//           |                              | o_repeat_seen
//  cfg      | i_cfg_we (no wait)           | i_cfg_index i_cfg_data
//
//  One request is taken per cycle while o_in_stall is low. The decoder state
//  sits in a one-word state RAM: a request reads it in the cycle it is
//  accepted; the modify stage then writes it back and loads any result into
//  the output register. Back-to-back requests see the word still in flight
//  through a bypass register.
//  Reset clears control state and marks the state word as never written, so
//  it reads as the cleared state; no clearing pass is needed.
//  A request that yields a result waits in the modify stage while the output
//  register is full and stalled; o_in_stall rises only then.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder
    import irpd_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TICK_W-1:0]    i_interval_ticks,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_frame_done,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_repeat_seen,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data
);

    localparam int unsigned SW = $bits(t_dec_state);
    localparam logic [POS_W-1:0] FRAME_END = POS_W'(FRAME_LEN);

    // ------------------------------------------------------------------
    // Window registers
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] r_header_low, r_header_high;
    logic [TICK_W-1:0] r_repeat_low, r_repeat_high;
    logic [TICK_W-1:0] r_one_low, r_one_high;
    logic [TICK_W-1:0] r_zero_low, r_zero_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_low  <= HEADER_LOW_RST;
            r_header_high <= HEADER_HIGH_RST;
            r_repeat_low  <= REPEAT_LOW_RST;
            r_repeat_high <= REPEAT_HIGH_RST;
            r_one_low     <= ONE_LOW_RST;
            r_one_high    <= ONE_HIGH_RST;
            r_zero_low    <= ZERO_LOW_RST;
            r_zero_high   <= ZERO_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER_LOW:  r_header_low  <= i_cfg_data;
                CFG_HEADER_HIGH: r_header_high <= i_cfg_data;
                CFG_REPEAT_LOW:  r_repeat_low  <= i_cfg_data;
                CFG_REPEAT_HIGH: r_repeat_high <= i_cfg_data;
                CFG_ONE_LOW:     r_one_low     <= i_cfg_data;
                CFG_ONE_HIGH:    r_one_high    <= i_cfg_data;
                CFG_ZERO_LOW:    r_zero_low    <= i_cfg_data;
                CFG_ZERO_HIGH:   r_zero_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic              r_s1_vld;      // request in modify stage
    logic [TICK_W-1:0] r_s1_ticks;
    logic              r_s1_init;     // state word had been written at read
    logic              r_byp_vld;     // write collided with the read
    t_dec_state        r_byp_state;
    logic              r_mem_init;    // state word written since reset

    logic              r_out_vld;
    logic              r_out_done;
    logic [STATUS_W-1:0] r_out_status;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_rep;

    logic              in_acc;
    logic              s1_go;
    logic              s1_fire;
    logic              out_free;
    logic              has_result;

    logic [SW-1:0]     ram_rdata;
    t_dec_state        cur_state;
    t_dec_state        n_state;
    logic              res_done;
    t_status           res_status;
    logic [BYTE_W-1:0] res_byte;
    logic              res_rep;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_go      = !has_result || out_free;
    assign s1_fire    = r_s1_vld && s1_go;
    assign o_in_stall = r_s1_vld && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    irpd_ram #(
        .WIDTH (SW),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (1'b0),
        .i_wdata (n_state),
        .i_re    (in_acc),
        .i_raddr (1'b0),
        .o_rdata (ram_rdata)
    );

    // Stage 0 -> 1: capture the request and note any write in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_mem_init <= 1'b0;
            r_byp_vld  <= 1'b0;
            r_s1_init  <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_mem_init <= 1'b1;
            end
            if (in_acc) begin
                r_s1_vld  <= 1'b1;
                r_byp_vld <= s1_fire;
                r_s1_init <= r_mem_init;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ticks  <= i_interval_ticks;
            r_byp_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: modify the state word
    // ------------------------------------------------------------------
    always_comb begin
        if (r_byp_vld) begin
            cur_state = r_byp_state;
        end else if (r_s1_init) begin
            cur_state = t_dec_state'(ram_rdata);
        end else begin
            cur_state = STATE_RST;
        end
    end

    always_comb begin
        logic             hdr;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] bit_off;
        logic [POS_W-1:0] next_pos;

        n_state    = cur_state;
        res_done   = 1'b0;
        res_status = ST_OK;
        res_byte   = '0;
        res_rep    = in_window(r_s1_ticks, r_repeat_low, r_repeat_high);
        hdr        = in_window(r_s1_ticks, r_header_low, r_header_high);
        p          = cur_state.position;
        bit_off    = p - DATA_LO;
        next_pos   = p + POS_W'(1);

        if (hdr) begin
            n_state.recording = 1'b1;
        end

        if (n_state.recording) begin
            if (p >= FIRST_LO && p <= FIRST_HI) begin
                if (r_s1_ticks > FIRST_LIMIT) begin
                    n_state.first_fail = 1'b1;
                end
            end else if (p >= SECOND_LO && p <= SECOND_HI) begin
                if (r_s1_ticks > SECOND_LIMIT) begin
                    n_state.second_fail = 1'b1;
                end
            end else if (p >= DATA_LO && p <= DATA_HI) begin
                if (in_window(r_s1_ticks, r_one_low, r_one_high)) begin
                    n_state.data_bits[bit_off[2:0]] = 1'b1;
                end else if (in_window(r_s1_ticks, r_zero_low, r_zero_high)) begin
                    n_state.data_bits[bit_off[2:0]] = 1'b0;
                end
            end
            n_state.position = next_pos;

            // Frame complete: report and rearm
            if (next_pos >= FRAME_END) begin
                res_done = 1'b1;
                if (n_state.first_fail) begin
                    res_status = ST_FIRST_FAIL;
                end else if (n_state.second_fail) begin
                    res_status = ST_SECOND_FAIL;
                end else begin
                    res_status = ST_OK;
                    res_byte   = n_state.data_bits;
                end
                n_state = STATE_RST;
            end
        end

        has_result = res_done || res_rep;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire && has_result) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && has_result) begin
            r_out_done   <= res_done;
            r_out_status <= res_status;
            r_out_byte   <= res_byte;
            r_out_rep    <= res_rep;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_frame_done  = r_out_done;
    assign o_status      = r_out_status;
    assign o_data_byte   = r_out_byte;
    assign o_repeat_seen = r_out_rep;

endmodule
